>>> src/dslc_pkg.sv
// shared types and constants for the display status line counter
`timescale 1ns / 1ps
`default_nettype none

package dslc_pkg;

   localparam int LINE_W   = 9;
   localparam int STATUS_W = 16;
   localparam int DATA_W   = 16;
   localparam int FUNC_W   = 2;

   localparam int VISIBLE_LINES_DEF   = 192;
   localparam int VBLANK_END_LINE_DEF = 262;
   localparam int LINES_PER_FRAME_DEF = 263;

   // writable bits of a status register, and the read-only flags
   localparam logic [STATUS_W-1:0] WRITE_MASK = 16'hFFB8;
   localparam logic [STATUS_W-1:0] RO_MASK    = 16'h0007;

   // status register bit positions
   localparam int F_VBLANK_BIT = 0;
   localparam int F_HBLANK_BIT = 1;
   localparam int F_MATCH_BIT  = 2;
   localparam int E_VBLANK_BIT = 3;
   localparam int E_HBLANK_BIT = 4;
   localparam int E_MATCH_BIT  = 5;
   localparam int ZERO_BIT     = 6;
   localparam int CMP_HI_BIT   = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE_A  = 2'd0,
      FUNC_WRITE_B  = 2'd1,
      FUNC_HBLANK   = 2'd2,
      FUNC_LINE_END = 2'd3
   } func_type;

   // result transaction, first field in the highest bits
   typedef struct packed {
      logic                render_request;
      logic                irq_b_line_match;
      logic                irq_b_hblank;
      logic                irq_b_vblank;
      logic                irq_a_line_match;
      logic                irq_a_hblank;
      logic                irq_a_vblank;
      logic [LINE_W-1:0]   line_count;
      logic [STATUS_W-1:0] status_b;
      logic [STATUS_W-1:0] status_a;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

`default_nettype wire

>>> src/display_status_line_counter_top.sv
// top level of the display status and scanline counter
`timescale 1ns / 1ps
`default_nettype none

// path: a request is held in the input register, then its response in the result register
// throughput: one transaction per cycle unless stalled by rsp_tready, set by the single
//   update pass from the input register through the status and line registers to the result register
// reset: synchronous, active high; clears both status registers, the line count
//   and both valid flags, so no response is pending after reset

module display_status_line_counter_top #(
   parameter int VISIBLE_LINES   = dslc_pkg::VISIBLE_LINES_DEF,
   parameter int VBLANK_END_LINE = dslc_pkg::VBLANK_END_LINE_DEF,
   parameter int LINES_PER_FRAME = dslc_pkg::LINES_PER_FRAME_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [dslc_pkg::DATA_W-1:0] req_tdata,  // [15:0] write_data
   input  wire logic [dslc_pkg::FUNC_W-1:0] req_tuser,  // [1:0] func
   // response channel
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [15:0] status_a, [31:16] status_b, [40:32] line_count, [41] irq_a_vblank,
   // [42] irq_a_hblank, [43] irq_a_line_match, [44] irq_b_vblank,
   // [45] irq_b_hblank, [46] irq_b_line_match, [47] render_request
   output      logic [dslc_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam logic [dslc_pkg::LINE_W-1:0] VIS_LINE  = dslc_pkg::LINE_W'(VISIBLE_LINES);
   localparam logic [dslc_pkg::LINE_W-1:0] VEND_LINE = dslc_pkg::LINE_W'(VBLANK_END_LINE);
   localparam logic [dslc_pkg::LINE_W-1:0] WRAP_LINE = dslc_pkg::LINE_W'(LINES_PER_FRAME);

   // input register
   logic                          in_valid_ff, in_valid_in;
   dslc_pkg::func_type            in_func_ff,  in_func_in;
   logic [dslc_pkg::DATA_W-1:0]   in_data_ff,  in_data_in;

   // block state
   logic [dslc_pkg::STATUS_W-1:0] status_a_ff, status_a_in;
   logic [dslc_pkg::STATUS_W-1:0] status_b_ff, status_b_in;
   logic [dslc_pkg::LINE_W-1:0]   line_ff,     line_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   dslc_pkg::rsp_type             rsp_data_ff,  rsp_data_in;

   logic                          req_take;
   logic                          advance;
   logic [dslc_pkg::LINE_W-1:0]   line_inc;
   logic                          match_a, match_b;

   // the update pass moves whenever the result register is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_func_in  = dslc_pkg::func_type'(req_tuser);
         in_data_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // compare line of each side: bit 7 is bit 8 of the line, the high byte the rest
   assign match_a = ({status_a_ff[dslc_pkg::CMP_HI_BIT], status_a_ff[15:8]} == line_ff);
   assign match_b = ({status_b_ff[dslc_pkg::CMP_HI_BIT], status_b_ff[15:8]} == line_ff);
   assign line_inc = line_ff + 1'b1;   // 9-bit wrap past 511 is intended

   // one event applied to the state, result formed from the updated state
   always_comb begin
      status_a_in = status_a_ff;
      status_b_in = status_b_ff;
      line_in     = line_ff;
      rsp_data_in = '0;
      case (in_func_ff)
         dslc_pkg::FUNC_WRITE_A: begin
            // read-only flags survive, bit 6 reads zero
            status_a_in = (in_data_ff & dslc_pkg::WRITE_MASK) |
                          (status_a_ff & dslc_pkg::RO_MASK);
         end
         dslc_pkg::FUNC_WRITE_B: begin
            status_b_in = (in_data_ff & dslc_pkg::WRITE_MASK) |
                          (status_b_ff & dslc_pkg::RO_MASK);
         end
         dslc_pkg::FUNC_HBLANK: begin
            rsp_data_in.render_request = (line_ff < VIS_LINE);
            status_a_in[dslc_pkg::F_HBLANK_BIT] = 1'b1;
            status_b_in[dslc_pkg::F_HBLANK_BIT] = 1'b1;
            rsp_data_in.irq_a_hblank = status_a_ff[dslc_pkg::E_HBLANK_BIT];
            rsp_data_in.irq_b_hblank = status_b_ff[dslc_pkg::E_HBLANK_BIT];
         end
         dslc_pkg::FUNC_LINE_END: begin
            // match uses the line before it advances
            status_a_in[dslc_pkg::F_MATCH_BIT]  = match_a;
            status_b_in[dslc_pkg::F_MATCH_BIT]  = match_b;
            rsp_data_in.irq_a_line_match = match_a && status_a_ff[dslc_pkg::E_MATCH_BIT];
            rsp_data_in.irq_b_line_match = match_b && status_b_ff[dslc_pkg::E_MATCH_BIT];
            status_a_in[dslc_pkg::F_HBLANK_BIT] = 1'b0;
            status_b_in[dslc_pkg::F_HBLANK_BIT] = 1'b0;
            line_in = line_inc;
            if (line_inc == VIS_LINE) begin
               status_a_in[dslc_pkg::F_VBLANK_BIT] = 1'b1;
               status_b_in[dslc_pkg::F_VBLANK_BIT] = 1'b1;
               rsp_data_in.irq_a_vblank = status_a_ff[dslc_pkg::E_VBLANK_BIT];
               rsp_data_in.irq_b_vblank = status_b_ff[dslc_pkg::E_VBLANK_BIT];
            end else if (line_inc == VEND_LINE) begin
               status_a_in[dslc_pkg::F_VBLANK_BIT] = 1'b0;
               status_b_in[dslc_pkg::F_VBLANK_BIT] = 1'b0;
            end else if (line_inc >= WRAP_LINE) begin
               line_in = '0;
            end
         end
         default: begin
         end
      endcase
      // state after this transaction goes out with it
      rsp_data_in.status_a   = status_a_in;
      rsp_data_in.status_b   = status_b_in;
      rsp_data_in.line_count = line_in;
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_a_ff  <= '0;
         status_b_ff  <= '0;
         line_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            status_a_ff <= status_a_in;
            status_b_ff <= status_b_in;
            line_ff     <= line_in;
         end
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_func_ff <= in_func_in;
      in_data_ff <= in_data_in;
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> src/dslc_checker.sv
// port-level checker for the display status line counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dslc_checker #(
   parameter int LINES_PER_FRAME = dslc_pkg::LINES_PER_FRAME_DEF
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [dslc_pkg::RSP_W-1:0] rsp_tdata
);

   dslc_pkg::rsp_type rsp;
   assign rsp = dslc_pkg::rsp_type'(rsp_tdata);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // line count never leaves the frame
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp.line_count) < LINES_PER_FRAME))
      else $error("line count out of frame");

   // status bit 6 always reads zero on both sides
   a_zero_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp.status_a[dslc_pkg::ZERO_BIT] && !rsp.status_b[dslc_pkg::ZERO_BIT])
      else $error("status bit 6 set");

   // hblank events and line end events never report together
   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.irq_a_hblank || rsp.irq_b_hblank || rsp.render_request) |->
         !(rsp.irq_a_vblank || rsp.irq_b_vblank ||
           rsp.irq_a_line_match || rsp.irq_b_line_match))
      else $error("hblank and line end irqs in one response");

endmodule

bind display_status_line_counter_top dslc_checker #(
   .LINES_PER_FRAME(LINES_PER_FRAME)
) u_dslc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
